@@ rtl/core/sgbu_pkg.sv @@
// Shared types, sizes and cell mapping for the spatial hash grid bucket update.
// Used by sgbu_ctrl, sgbu_datapath and spatial_hash_grid_bucket_update.
// Has no dependencies of its own.
package sgbu_pkg;

  // Grid and store sizes.
  localparam int EntityCount  = 1024;
  localparam int CellsPerAxis = 32;
  localparam int CellSize     = 32;
  localparam int MapSize      = 1024;

  localparam int NumCells  = CellsPerAxis * CellsPerAxis;
  localparam int NumNodes  = EntityCount + 1;
  localparam int IdW       = 10;
  localparam int CellW     = 10;
  localparam int NodeW     = $clog2(NumNodes);
  localparam int StepW     = $clog2(EntityCount + 2);
  localparam int AxisW     = $clog2(CellsPerAxis);
  localparam int CellShift = $clog2(CellSize);
  localparam int PosW      = 16;

  // Result status codes.
  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StFull    = 2'd1,
    StMissing = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;       // clear one entry of the cell and entity tables
    logic accept;      // take the input item and read its tables
    logic ins_commit;  // push a fresh node on the new cell
    logic ins_full;    // node store is full, report recorded cell
    logic move_same;   // move inside the same cell, nothing to do
    logic move_start;  // record new cell and read the old bucket head
    logic head_load;   // start the walk at the old bucket head
    logic node_rd;     // read the current node
    logic node_step;   // advance to the next node
    logic miss;        // walk ended without finding the entity
    logic unlink;      // drop the found node from the old bucket
    logic link;        // push the found node on the new cell
    logic out_load;    // move the pending result to the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;    // last entry of the clearing pass
    logic is_move;
    logic store_full;
    logic same_cell;
    logic walk_end;    // current node is null, out of range or step limit reached
    logic match;       // current node holds the entity
  } sts_t;

  // Clamp one coordinate to the map and map it to a cell column or row.
  function automatic logic [AxisW-1:0] axis_cell(input logic signed [PosW-1:0] p);
    logic [PosW-1:0] v;
    logic [PosW-1:0] q;
    if (p < 0) begin
      v = '0;
    end else if (p > PosW'(MapSize - 1)) begin
      v = PosW'(MapSize - 1);
    end else begin
      v = p;
    end
    q = v >> CellShift;
    if (q > PosW'(CellsPerAxis - 1)) begin
      q = PosW'(CellsPerAxis - 1);
    end
    return q[AxisW-1:0];
  endfunction

  // Linear cell index of a position: column plus row times cells per axis.
  function automatic logic [CellW-1:0] cell_of(input logic signed [PosW-1:0] x,
                                               input logic signed [PosW-1:0] y);
    logic [CellW-1:0] cx;
    logic [CellW-1:0] cy;
    cx = CellW'(axis_cell(x));
    cy = CellW'(axis_cell(y));
    return cx + CellW'(CellsPerAxis) * cy;
  endfunction

endpackage

@@ rtl/core/sgbu_ctrl.sv @@
// Controller state machine for the spatial hash grid bucket update.
// Depends on sgbu_pkg for the command and status structs.
module sgbu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  sgbu_pkg::sts_t sts_i,
  output sgbu_pkg::cmd_t cmd_o
);

  typedef enum logic [7:0] {
    StClear = 8'b0000_0001,
    StIdle  = 8'b0000_0010,
    StFirst = 8'b0000_0100,
    StHead  = 8'b0000_1000,
    StWalk  = 8'b0001_0000,
    StNode  = 8'b0010_0000,
    StLink  = 8'b0100_0000,
    StDone  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Input is taken only when no item is in progress and the tables are clear.
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StClear: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StFirst;
        end
      end
      StFirst: begin
        if (!sts_i.is_move) begin
          if (sts_i.store_full) begin
            cmd_o.ins_full = 1'b1;
          end else begin
            cmd_o.ins_commit = 1'b1;
          end
          state_d = StDone;
        end else if (sts_i.same_cell) begin
          cmd_o.move_same = 1'b1;
          state_d         = StDone;
        end else begin
          cmd_o.move_start = 1'b1;
          state_d          = StHead;
        end
      end
      StHead: begin
        cmd_o.head_load = 1'b1;
        state_d         = StWalk;
      end
      StWalk: begin
        if (sts_i.walk_end) begin
          cmd_o.miss = 1'b1;
          state_d    = StDone;
        end else begin
          cmd_o.node_rd = 1'b1;
          state_d       = StNode;
        end
      end
      StNode: begin
        if (sts_i.match) begin
          cmd_o.unlink = 1'b1;
          state_d      = StLink;
        end else begin
          cmd_o.node_step = 1'b1;
          state_d         = StWalk;
        end
      end
      StLink: begin
        cmd_o.link = 1'b1;
        state_d    = StDone;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output valid: set on load, cleared when the transfer completes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // An accepted item always starts with the first table read.
  a_accept_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == StFirst))
    else $error("accepted item did not enter the first read");

  // A waiting result is never overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && out_valid_q && !out_ready_i) |=> (state_q == StDone))
    else $error("result left done state while output was stalled");

  // A matching node is always relinked right after it is found.
  a_match_links: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StNode && sts_i.match) |=> (state_q == StLink))
    else $error("found node was not relinked");

endmodule

@@ rtl/core/sgbu_datapath.sv @@
// Datapath for the spatial hash grid bucket update: tables, node store,
// bucket walk registers and result registers. Depends on sgbu_pkg.
module sgbu_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sgbu_pkg::cmd_t                  cmd_i,
  output sgbu_pkg::sts_t                  sts_o,
  input  logic                            action_i,
  input  logic [sgbu_pkg::IdW-1:0]        entity_id_i,
  input  logic signed [sgbu_pkg::PosW-1:0] pos_x_i,
  input  logic signed [sgbu_pkg::PosW-1:0] pos_y_i,
  output logic [sgbu_pkg::CellW-1:0]      cell_index_o,
  output logic                            cell_changed_o,
  output logic [1:0]                      status_o
);

  // Memories.
  logic [sgbu_pkg::NodeW-1:0] heads_mem  [sgbu_pkg::NumCells];
  logic [sgbu_pkg::CellW-1:0] ecell_mem  [sgbu_pkg::EntityCount];
  logic [sgbu_pkg::IdW-1:0]   nent_mem   [sgbu_pkg::NumNodes];
  logic [sgbu_pkg::NodeW-1:0] nnext_mem  [sgbu_pkg::NumNodes];

  // Registered read data.
  logic [sgbu_pkg::NodeW-1:0] head_rd_q;
  logic [sgbu_pkg::CellW-1:0] ecell_rd_q;
  logic [sgbu_pkg::IdW-1:0]   nent_rd_q;
  logic [sgbu_pkg::NodeW-1:0] nnext_rd_q;

  // Item and walk registers.
  logic                       action_q;
  logic [sgbu_pkg::IdW-1:0]   id_q;
  logic [sgbu_pkg::CellW-1:0] cell_q;
  logic [sgbu_pkg::CellW-1:0] old_q;
  logic [sgbu_pkg::NodeW-1:0] cur_q;
  logic [sgbu_pkg::NodeW-1:0] prev_q;
  logic [sgbu_pkg::StepW-1:0] steps_q;
  logic [sgbu_pkg::NodeW-1:0] fresh_q;
  logic [sgbu_pkg::CellW-1:0] clr_q;

  // Pending and output result registers.
  logic [sgbu_pkg::CellW-1:0] pend_cell_q;
  logic                       pend_changed_q;
  sgbu_pkg::status_e          pend_status_q;
  logic [sgbu_pkg::CellW-1:0] res_cell_q;
  logic                       res_changed_q;
  sgbu_pkg::status_e          res_status_q;

  logic [sgbu_pkg::CellW-1:0] in_cell;

  // Port controls.
  logic                       heads_we, heads_re;
  logic [sgbu_pkg::CellW-1:0] heads_wa, heads_ra;
  logic [sgbu_pkg::NodeW-1:0] heads_wd;
  logic                       ecell_we;
  logic [sgbu_pkg::IdW-1:0]   ecell_wa;
  logic [sgbu_pkg::CellW-1:0] ecell_wd;
  logic                       nnext_we;
  logic [sgbu_pkg::NodeW-1:0] nnext_wa, nnext_wd;

  assign in_cell = sgbu_pkg::cell_of(pos_x_i, pos_y_i);

  // Status toward the controller.
  always_comb begin
    sts_o.clr_last   = (clr_q == sgbu_pkg::CellW'(sgbu_pkg::NumCells - 1));
    sts_o.is_move    = action_q;
    sts_o.store_full = (fresh_q > sgbu_pkg::NodeW'(sgbu_pkg::EntityCount));
    sts_o.same_cell  = (ecell_rd_q == cell_q);
    sts_o.walk_end   = (cur_q == '0) ||
                       (cur_q > sgbu_pkg::NodeW'(sgbu_pkg::EntityCount)) ||
                       (steps_q > sgbu_pkg::StepW'(sgbu_pkg::EntityCount));
    sts_o.match      = (nent_rd_q == id_q);
  end

  // Cell head table port selection.
  always_comb begin
    heads_we = 1'b0;
    heads_wa = '0;
    heads_wd = '0;
    if (cmd_i.clear) begin
      heads_we = 1'b1;
      heads_wa = clr_q;
    end else if (cmd_i.ins_commit) begin
      heads_we = 1'b1;
      heads_wa = cell_q;
      heads_wd = fresh_q;
    end else if (cmd_i.unlink && prev_q == '0) begin
      heads_we = 1'b1;
      heads_wa = old_q;
      heads_wd = nnext_rd_q;
    end else if (cmd_i.link) begin
      heads_we = 1'b1;
      heads_wa = cell_q;
      heads_wd = cur_q;
    end
    heads_re = cmd_i.accept || cmd_i.move_start || cmd_i.unlink;
    if (cmd_i.accept) begin
      heads_ra = in_cell;
    end else if (cmd_i.move_start) begin
      heads_ra = ecell_rd_q;
    end else begin
      heads_ra = cell_q;
    end
  end

  // Entity cell table and node link port selection.
  always_comb begin
    ecell_we = cmd_i.clear || cmd_i.ins_commit || cmd_i.move_start;
    ecell_wa = cmd_i.clear ? clr_q : id_q;
    ecell_wd = cmd_i.clear ? '0 : cell_q;
    nnext_we = 1'b0;
    nnext_wa = '0;
    nnext_wd = '0;
    if (cmd_i.ins_commit) begin
      nnext_we = 1'b1;
      nnext_wa = fresh_q;
      nnext_wd = head_rd_q;
    end else if (cmd_i.unlink && prev_q != '0) begin
      nnext_we = 1'b1;
      nnext_wa = prev_q;
      nnext_wd = nnext_rd_q;
    end else if (cmd_i.link) begin
      nnext_we = 1'b1;
      nnext_wa = cur_q;
      nnext_wd = head_rd_q;
    end
  end

  // Cell head memory.
  always_ff @(posedge clk_i) begin
    if (heads_we) begin
      heads_mem[heads_wa] <= heads_wd;
    end
    if (heads_re) begin
      head_rd_q <= heads_mem[heads_ra];
    end
  end

  // Entity cell memory.
  always_ff @(posedge clk_i) begin
    if (ecell_we) begin
      ecell_mem[ecell_wa] <= ecell_wd;
    end
    if (cmd_i.accept) begin
      ecell_rd_q <= ecell_mem[entity_id_i];
    end
  end

  // Node entity memory.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_commit) begin
      nent_mem[fresh_q] <= id_q;
    end
    if (cmd_i.node_rd) begin
      nent_rd_q <= nent_mem[cur_q];
    end
  end

  // Node link memory.
  always_ff @(posedge clk_i) begin
    if (nnext_we) begin
      nnext_mem[nnext_wa] <= nnext_wd;
    end
    if (cmd_i.node_rd) begin
      nnext_rd_q <= nnext_mem[cur_q];
    end
  end

  // Item and walk payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= action_i;
      id_q     <= entity_id_i;
      cell_q   <= in_cell;
    end
    if (cmd_i.move_start) begin
      old_q <= ecell_rd_q;
    end
    if (cmd_i.head_load) begin
      cur_q  <= head_rd_q;
      prev_q <= '0;
    end else if (cmd_i.node_step) begin
      cur_q  <= nnext_rd_q;
      prev_q <= cur_q;
    end
  end

  // Step counter, fresh node pointer and clearing address.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
      fresh_q <= sgbu_pkg::NodeW'(1);
      clr_q   <= '0;
    end else begin
      if (cmd_i.head_load) begin
        steps_q <= '0;
      end else if (cmd_i.node_step) begin
        steps_q <= steps_q + sgbu_pkg::StepW'(1);
      end
      if (cmd_i.ins_commit) begin
        fresh_q <= fresh_q + sgbu_pkg::NodeW'(1);
      end
      if (cmd_i.clear) begin
        clr_q <= clr_q + sgbu_pkg::CellW'(1);
      end
    end
  end

  // Pending result, set where the outcome of the item is decided.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_full) begin
      pend_cell_q    <= ecell_rd_q;
      pend_changed_q <= 1'b0;
      pend_status_q  <= sgbu_pkg::StFull;
    end else if (cmd_i.ins_commit || cmd_i.move_same) begin
      pend_cell_q    <= cell_q;
      pend_changed_q <= 1'b0;
      pend_status_q  <= sgbu_pkg::StOk;
    end else if (cmd_i.miss) begin
      pend_cell_q    <= cell_q;
      pend_changed_q <= 1'b0;
      pend_status_q  <= sgbu_pkg::StMissing;
    end else if (cmd_i.link) begin
      pend_cell_q    <= cell_q;
      pend_changed_q <= 1'b1;
      pend_status_q  <= sgbu_pkg::StOk;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_cell_q    <= pend_cell_q;
      res_changed_q <= pend_changed_q;
      res_status_q  <= pend_status_q;
    end
  end

  assign cell_index_o   = res_cell_q;
  assign cell_changed_o = res_changed_q;
  assign status_o       = res_status_q;

  // The fresh node pointer never passes one beyond the last node.
  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= sgbu_pkg::NodeW'(sgbu_pkg::NumNodes))
    else $error("fresh node pointer ran past the node store");

  // Only a real node is pushed on the new cell.
  a_link_nonnull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.link |-> (cur_q != '0))
    else $error("null node linked into a bucket");

  // A walk step is only taken from a node that did not match.
  a_step_nomatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.node_step |-> (nent_rd_q != id_q))
    else $error("walk stepped past a matching node");

endmodule

@@ rtl/core/spatial_hash_grid_bucket_update.sv @@
// Top level of the spatial hash grid bucket update.
// Instantiates sgbu_ctrl and sgbu_datapath; depends on sgbu_pkg.
//
//   Channel  Direction  Handshake               Payload
//   input    in         in_valid_i/in_ready_o   action_i, entity_id_i, pos_x_i, pos_y_i
//   output   out        out_valid_o/out_ready_i cell_index_o, cell_changed_o, status_o
//
// An insert, a full store or a move within the same cell goes from the first read straight to done.
// A move to another cell loads the old bucket head, then walks the bucket, reading one
// node at a time through the node store read port, and relinks the node it finds.
// After reset a clearing pass empties the cell tables; in_ready_o is low.
// One item is in work at a time; the next is accepted while a result waits, and its
// result is held until the output register is free.
module spatial_hash_grid_bucket_update (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             action_i,
  input  logic [sgbu_pkg::IdW-1:0]         entity_id_i,
  input  logic signed [sgbu_pkg::PosW-1:0] pos_x_i,
  input  logic signed [sgbu_pkg::PosW-1:0] pos_y_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sgbu_pkg::CellW-1:0]       cell_index_o,
  output logic                             cell_changed_o,
  output logic [1:0]                       status_o
);

  sgbu_pkg::cmd_t cmd;
  sgbu_pkg::sts_t sts;

  // Sequencer.
  sgbu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Tables, node store and result registers.
  sgbu_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (action_i),
    .entity_id_i    (entity_id_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .cell_index_o   (cell_index_o),
    .cell_changed_o (cell_changed_o),
    .status_o       (status_o)
  );

endmodule

@@ tb/sv/sgbu_bucket_checker.sv @@
// Scoreboard for the spatial hash grid bucket update: a bucket-list predictor and result compare.
// Holds sgbu_tb_pkg (action codes) and sgbu_bucket_checker.
// Depends on sgbu_pkg for sizes and status codes.
package sgbu_tb_pkg;

  // Operation carried by one input transfer.
  typedef enum logic {
    ActInsert = 1'b0,
    ActMove   = 1'b1
  } action_e;

endpackage

module sgbu_bucket_checker
  import sgbu_pkg::*;
  import sgbu_tb_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    action_i,
  input  logic [IdW-1:0]          entity_id_i,
  input  logic signed [PosW-1:0]  pos_x_i,
  input  logic signed [PosW-1:0]  pos_y_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [CellW-1:0]        cell_index_i,
  input  logic                    cell_changed_i,
  input  logic [1:0]              status_i,
  output int unsigned             failures_o,
  output int unsigned             awaited_o
);

  typedef struct packed {
    logic [CellW-1:0] cell_idx;
    logic             moved;
    status_e          status;
  } bucket_result_t;

  // Shadow copy of the grid: bucket heads, node contents and per-entity cells.
  logic [NodeW-1:0] head_of_cell   [NumCells];
  logic [IdW-1:0]   owner_of_node  [NumNodes];
  logic [NodeW-1:0] link_of_node   [NumNodes];
  logic [CellW-1:0] cell_of_entity [EntityCount];
  int               fresh_node;

  bucket_result_t awaited_results[$];
  int unsigned    fail_count = 0;

  // Clamp one coordinate to the map and turn it into a column or row number.
  function automatic int clamp_axis(input logic signed [PosW-1:0] p);
    int v;
    v = p;
    if (v < 0) v = 0;
    if (v > MapSize - 1) v = MapSize - 1;
    v = v / CellSize;
    if (v > CellsPerAxis - 1) v = CellsPerAxis - 1;
    return v;
  endfunction

  function automatic logic [CellW-1:0] grid_cell(input logic signed [PosW-1:0] px,
                                                 input logic signed [PosW-1:0] py);
    return CellW'(clamp_axis(px) + CellsPerAxis * clamp_axis(py));
  endfunction

  // Apply one insert or move to the shadow grid and return the result it must give.
  // Every 10-bit id is below the entity count, so the out-of-range case cannot arise.
  function automatic bucket_result_t predict_bucket_update(input action_e act,
                                                           input logic [IdW-1:0] id,
                                                           input logic signed [PosW-1:0] px,
                                                           input logic signed [PosW-1:0] py);
    bucket_result_t r;
    logic [CellW-1:0] dest;
    logic [CellW-1:0] src;
    int cur;
    int prev;
    int steps;
    bit found;
    dest = grid_cell(px, py);
    r.moved = 1'b0;
    r.status = StOk;
    if (act == ActInsert) begin
      if (fresh_node > EntityCount) begin
        // Node store exhausted: nothing changes.
        r.status = StFull;
      end else begin
        cell_of_entity[id] = dest;
        owner_of_node[fresh_node] = id;
        link_of_node[fresh_node] = head_of_cell[dest];
        head_of_cell[dest] = NodeW'(fresh_node);
        fresh_node++;
      end
    end else begin
      src = cell_of_entity[id];
      if (src != dest) begin
        cell_of_entity[id] = dest;
        cur = head_of_cell[src];
        prev = 0;
        steps = 0;
        found = 1'b0;
        // Walk the old bucket; give up after one pass over the whole store.
        while (!found && cur != 0 && cur < NumNodes && steps <= EntityCount) begin
          if (owner_of_node[cur] == id) begin
            found = 1'b1;
          end else begin
            prev = cur;
            cur = link_of_node[cur];
            steps++;
          end
        end
        if (found) begin
          if (prev == 0) begin
            head_of_cell[src] = link_of_node[cur];
          end else begin
            link_of_node[prev] = link_of_node[cur];
          end
          link_of_node[cur] = head_of_cell[dest];
          head_of_cell[dest] = NodeW'(cur);
          r.moved = 1'b1;
        end else begin
          r.status = StMissing;
        end
      end
    end
    r.cell_idx = cell_of_entity[id];
    return r;
  endfunction

  // Predict on each input transfer and compare on each output transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    bucket_result_t want;
    if (!rst_ni) begin
      for (int c = 0; c < NumCells; c++) head_of_cell[c] = '0;
      for (int n = 0; n < NumNodes; n++) begin
        owner_of_node[n] = '0;
        link_of_node[n] = '0;
      end
      for (int e = 0; e < EntityCount; e++) cell_of_entity[e] = '0;
      fresh_node = 1;
      awaited_results.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        awaited_results.push_back(predict_bucket_update(action_e'(action_i), entity_id_i,
                                                        pos_x_i, pos_y_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result transfer: cell_index %0d cell_changed %0d status %0d",
                 cell_index_i, cell_changed_i, status_i);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (cell_index_i !== want.cell_idx) begin
            $error("cell_index: expected %0d, actual %0d", want.cell_idx, cell_index_i);
            fail_count++;
          end
          if (cell_changed_i !== want.moved) begin
            $error("cell_changed: expected %0d, actual %0d", want.moved, cell_changed_i);
            fail_count++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_i);
            fail_count++;
          end
        end
      end
    end
    failures_o <= fail_count;
    awaited_o <= awaited_results.size();
  end

endmodule

@@ tb/sv/tb_spatial_hash_grid_bucket_update.sv @@
// Testbench top for spatial_hash_grid_bucket_update: clock, reset, stimulus and verdict.
// Depends on sgbu_pkg, the block itself and sgbu_bucket_checker (with sgbu_tb_pkg).
module tb_spatial_hash_grid_bucket_update;
  import sgbu_pkg::*;
  import sgbu_tb_pkg::*;

  localparam int RandomItems = 2000;
  localparam int DrainCycles = 40;
  localparam int CycleLimit  = 20_000_000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic                   action_i = ActInsert;
  logic [IdW-1:0]         entity_id_i = '0;
  logic signed [PosW-1:0] pos_x_i = '0;
  logic signed [PosW-1:0] pos_y_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [CellW-1:0]       cell_index_o;
  logic                   cell_changed_o;
  logic [1:0]             status_o;

  int unsigned failures;
  int unsigned awaited;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  longint      cycle_count = 0;

  spatial_hash_grid_bucket_update dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .entity_id_i    (entity_id_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cell_index_o   (cell_index_o),
    .cell_changed_o (cell_changed_o),
    .status_o       (status_o)
  );

  sgbu_bucket_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .action_i       (action_i),
    .entity_id_i    (entity_id_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cell_index_i   (cell_index_o),
    .cell_changed_i (cell_changed_o),
    .status_i       (status_o),
    .failures_o     (failures),
    .awaited_o      (awaited)
  );

  always #5 clk_i = ~clk_i;

  // Receiver backpressure, redrawn every cycle.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Hang guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_spatial_hash_grid_bucket_update: FAIL");
      $finish;
    end
  end

  // Offer one item, with random gaps ahead of it, and hold it until the transfer.
  task automatic send_item(input action_e act, input logic [IdW-1:0] id,
                           input logic signed [PosW-1:0] px,
                           input logic signed [PosW-1:0] py);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    entity_id_i <= id;
    pos_x_i <= px;
    pos_y_i <= py;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Often a small crowded corner so buckets grow long, plus edges and the full range.
  function automatic logic signed [PosW-1:0] pick_coord();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 45) return PosW'($urandom_range(95));
    if (sel < 65) return PosW'($urandom_range(1023));
    if (sel < 85) return PosW'($urandom());
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return -16'sd1;
      2: return 16'sd0;
      3: return 16'sd31;
      4: return 16'sd32;
      5: return 16'sd1023;
      6: return 16'sd1024;
      default: return 16'sh7fff;
    endcase
  endfunction

  // A small working set keeps moves hitting live entities; the rest are often missing.
  function automatic logic [IdW-1:0] pick_entity();
    if ($urandom_range(99) < 70) return IdW'($urandom_range(47));
    return IdW'($urandom_range(1023));
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: corners of the map, clamping, cell boundaries and bucket surgery.
    tx_idle_pct = 16;
    rx_idle_pct = 49;
    send_item(ActInsert, 10'd0, 16'sh8000, 16'sh8000);
    send_item(ActInsert, 10'd1023, 16'sh7fff, 16'sh7fff);
    send_item(ActInsert, 10'd5, 16'sd1023, 16'sd0);
    send_item(ActInsert, 10'd6, 16'sd31, 16'sd32);
    send_item(ActInsert, 10'd7, 16'sd32, 16'sd31);
    // Move that stays in the same cell after clamping.
    send_item(ActMove, 10'd5, 16'sd1024, -16'sd5);
    // Move of a bucket head.
    send_item(ActMove, 10'd0, 16'sd100, 16'sd100);
    // Duplicate insert, then move the latest copy out.
    send_item(ActInsert, 10'd6, 16'sd500, 16'sd500);
    send_item(ActMove, 10'd6, 16'sd0, 16'sd0);
    // Entity never inserted: recorded in cell zero but absent from its bucket.
    send_item(ActMove, 10'd300, 16'sd700, 16'sd700);
    send_item(ActMove, 10'd300, 16'sd700, 16'sd700);
    // Three in one cell: unlink the tail, then the new tail and then the head.
    send_item(ActInsert, 10'd10, 16'sd40, 16'sd40);
    send_item(ActInsert, 10'd11, 16'sd40, 16'sd40);
    send_item(ActInsert, 10'd12, 16'sd40, 16'sd40);
    send_item(ActMove, 10'd10, 16'sd200, 16'sd40);
    send_item(ActMove, 10'd11, 16'sd200, 16'sd40);
    send_item(ActMove, 10'd12, 16'sd40, 16'sd200);
    send_item(ActMove, 10'd10, 16'sd40, 16'sd40);
    // Move of the latest copy back into cell 32, where the older duplicate stays.
    send_item(ActMove, 10'd6, 16'sd31, 16'sd32);
    send_item(ActMove, 10'd1023, 16'sh8000, 16'sh7fff);

    // Random part in three idling phases; inserts dominate so the node store runs out.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 16;
          rx_idle_pct = 49;
        end
        1: begin
          tx_idle_pct = 49;
          rx_idle_pct = 16;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      repeat (RandomItems / 3) begin
        send_item(($urandom_range(99) < 60) ? ActInsert : ActMove, pick_entity(),
                  pick_coord(), pick_coord());
      end
    end
    in_valid_i <= 1'b0;

    // Let the last prediction land, then drain the outstanding results.
    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (failures == 0) begin
      $display("tb_spatial_hash_grid_bucket_update: PASS");
    end else begin
      $display("tb_spatial_hash_grid_bucket_update: FAIL");
    end
    $finish;
  end

endmodule
